FILE: design/i2p_pkg.sv
// Shared types, character codes and the precedence function of the infix to postfix converter.
`default_nettype none

package i2p_pkg;

  localparam int unsigned StackDepthDef = 16;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    KIND_SYM = 2'd0,
    KIND_END = 2'd1,
    KIND_OVF = 2'd2,
    KIND_UNM = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TOP,
    S_PUSH,
    S_FIN,
    S_DONE
  } seq_state_e;

  // Result request from the sequencer to the output stage.
  typedef struct packed {
    logic       put;
    logic       flush;
    logic [7:0] sym;
    kind_e      kind;
  } out_req_t;

  // Output stage status back to the sequencer.
  typedef struct packed {
    logic ok;
    logic out_free;
  } out_sts_t;

  // Precedence rank: 2 for * and /, 1 for + and -, 0 for everything else.
  // The rank keeps the order of the signed precedence where the lowest is -1.
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_MUL || c == CH_DIV) begin
      p = 2'd2;
    end else if (c == CH_ADD || c == CH_SUB) begin
      p = 2'd1;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: design/i2p_stack.sv
// Operator stack storage: one write port and one registered read port.
`default_nettype none

module i2p_stack import i2p_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef,
  localparam int unsigned AddrW = $clog2(StackDepth)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [7:0]       wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [7:0]       rd_data_o
);

  logic [7:0] mem [StackDepth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: design/i2p_out.sv
// Output stage: a hold register that delays each result until it is known whether it is the last.
`default_nettype none

module i2p_out import i2p_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire out_req_t   req_i,
  output out_sts_t        sts_o,
  output logic            m_valid_o,
  input  wire logic       m_ready_i,
  output logic [7:0]      m_sym_o,
  output kind_e           m_kind_o,
  output logic            m_last_o
);

  logic       hold_v_q, hold_v_d;
  logic [7:0] hold_sym_q;
  kind_e      hold_kind_q;
  logic       out_v_q, out_v_d;
  logic [7:0] out_sym_q;
  kind_e      out_kind_q;
  logic       out_last_q;
  logic       out_free;
  logic       move;

  assign out_free = !out_v_q || m_ready_i;
  assign sts_o.out_free = out_free;
  assign sts_o.ok = !hold_v_q || out_free;

  // A new result or the end of the item pushes the held result out.
  assign move = hold_v_q && (req_i.put || req_i.flush);

  always_comb begin
    hold_v_d = hold_v_q;
    if (req_i.put) begin
      hold_v_d = 1'b1;
    end else if (req_i.flush) begin
      hold_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (move) begin
      out_v_d = 1'b1;
    end else if (m_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.put) begin
      hold_sym_q  <= req_i.sym;
      hold_kind_q <= req_i.kind;
    end
    if (move) begin
      out_sym_q  <= hold_sym_q;
      out_kind_q <= hold_kind_q;
      out_last_q <= req_i.flush;
    end
  end

  assign m_valid_o = out_v_q;
  assign m_sym_o   = out_sym_q;
  assign m_kind_o  = out_kind_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: design/i2p_seq.sv
// Sequencer: decodes each character and walks the stack one entry per step through the
// shared precedence compare.
`default_nettype none

module i2p_seq import i2p_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef,
  localparam int unsigned AddrW = $clog2(StackDepth),
  localparam int unsigned CntW = $clog2(StackDepth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             in_cmd_i,
  input  wire logic [7:0]       in_ch_i,
  output logic                  wr_en_o,
  output logic      [AddrW-1:0] wr_addr_o,
  output logic      [7:0]       wr_data_o,
  output logic                  rd_en_o,
  output logic      [AddrW-1:0] rd_addr_o,
  input  wire logic [7:0]       rd_data_i,
  output out_req_t              req_o,
  input  wire out_sts_t         sts_i
);

  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntFull = CntW'(StackDepth);

  seq_state_e      state_q, state_d;
  logic            cmd_q;
  logic [7:0]      ch_q;
  kind_e           fin_kind_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cnt_dec;
  logic [CntW-1:0] cnt_dec2;
  logic            accept;
  logic            is_digit;
  logic            pop_op;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign is_digit = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign cnt_dec  = count_q - CntOne;
  assign cnt_dec2 = cnt_dec - CntOne;
  // The shared compare: an operator pops the top while its rank is not above the top's.
  assign pop_op   = prec_of(ch_q) <= prec_of(rd_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= in_cmd_i;
      ch_q       <= in_ch_i;
      fin_kind_q <= in_cmd_i ? KIND_END : KIND_UNM;
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    in_ready_o = 1'b0;
    wr_en_o    = 1'b0;
    wr_addr_o  = count_q[AddrW-1:0];
    wr_data_o  = ch_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = cnt_dec[AddrW-1:0];
    req_o      = '{put: 1'b0, flush: 1'b0, sym: 8'd0, kind: KIND_SYM};

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (cmd_q) begin
          if (count_q == '0) begin
            state_d = S_FIN;
          end else begin
            rd_en_o = 1'b1;
            state_d = S_TOP;
          end
        end else if (is_digit) begin
          if (sts_i.ok) begin
            req_o.put = 1'b1;
            req_o.sym = ch_q;
            state_d   = S_DONE;
          end
        end else if (ch_q == CH_LPAREN) begin
          state_d = S_PUSH;
        end else if (count_q == '0) begin
          state_d = (ch_q == CH_RPAREN) ? S_FIN : S_PUSH;
        end else begin
          rd_en_o = 1'b1;
          state_d = S_TOP;
        end
      end

      // The top entry sits in the read register; pop it, then read the next one.
      S_TOP: begin
        if (!cmd_q && ch_q == CH_RPAREN && rd_data_i == CH_LPAREN) begin
          count_d = cnt_dec;
          state_d = S_DONE;
        end else if (!cmd_q && ch_q != CH_RPAREN && !pop_op) begin
          state_d = S_PUSH;
        end else if (sts_i.ok) begin
          req_o.put = 1'b1;
          req_o.sym = rd_data_i;
          count_d   = cnt_dec;
          if (cnt_dec == '0) begin
            state_d = (cmd_q || ch_q == CH_RPAREN) ? S_FIN : S_PUSH;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = cnt_dec2[AddrW-1:0];
          end
        end
      end

      S_PUSH: begin
        if (count_q == CntFull) begin
          if (sts_i.ok) begin
            req_o.put  = 1'b1;
            req_o.kind = KIND_OVF;
            state_d    = S_DONE;
          end
        end else begin
          wr_en_o = 1'b1;
          count_d = count_q + CntOne;
          state_d = S_DONE;
        end
      end

      S_FIN: begin
        if (sts_i.ok) begin
          req_o.put  = 1'b1;
          req_o.kind = fin_kind_q;
          state_d    = S_DONE;
        end
      end

      S_DONE: begin
        if (sts_i.out_free) begin
          req_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix to postfix converter.
//
// The slave stream takes one infix character per request: tdata carries the
// character and tuser the command (0 character, 1 end of expression). The
// master stream returns the postfix results: tdata the symbol, tuser the kind
// (0 symbol, 1 end, 2 stack overflow, 3 unmatched close paren) and tlast the
// final result of each request. A request may give no result at all.
// One request is taken at a time; s_axis_tready_o is low while it is worked.
// A digit request goes from the idle state through decode and done back to
// idle, and its result passes through the hold register to the output
// register. Each stack entry that a request pops costs a pass through the
// sequencer's top state, since the top entry is read from the stack memory
// through its registered read port. Each result waits in the hold register
// until the next result or the end of its request, so tlast can be set once
// the request is known to be finished. Reset empties the stack and clears
// both output registers; the stack contents are not cleared. When the
// receiver stalls, the sequencer waits and no result is lost.
`default_nettype none

module infix_to_postfix_converter import i2p_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] ch
  input  wire logic       s_axis_tuser_i,   // [0] cmd
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] sym
  output logic [1:0]      m_axis_tuser_o,   // [1:0] kind
  output logic            m_axis_tlast_o    // last
);

  localparam int unsigned AddrW = $clog2(StackDepth);

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  out_req_t         req;
  out_sts_t         sts;
  kind_e            m_kind;

  i2p_seq #(
    .StackDepth(StackDepth)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (s_axis_tuser_i),
    .in_ch_i    (s_axis_tdata_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .req_o      (req),
    .sts_i      (sts)
  );

  i2p_stack #(
    .StackDepth(StackDepth)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  i2p_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .sts_o     (sts),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_sym_o   (m_axis_tdata_o),
    .m_kind_o  (m_kind),
    .m_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = m_kind;

endmodule

`default_nettype wire

FILE: design/i2p_checker.sv
// Port-level checker for the infix to postfix converter, bound to the top level.
`default_nettype none

module i2p_checker import i2p_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_tvalid_i,
  input wire logic       s_tready_i,
  input wire logic       m_tvalid_i,
  input wire logic       m_tready_i,
  input wire logic [7:0] m_tdata_i,
  input wire logic [1:0] m_tuser_i,
  input wire logic       m_tlast_i
);

  // Only one request is worked at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input taken again right after a request");

  // End, overflow and unmatched results carry no symbol.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i != KIND_SYM) |-> (m_tdata_i == 8'd0))
    else $error("non-symbol result with nonzero data");

  // Every non-symbol result closes its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i != KIND_SYM) |-> m_tlast_i)
    else $error("non-symbol result without tlast");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("stalled result changed");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);

`default_nettype wire

FILE: tb/i2p_checker.sv
// Scoreboard that predicts the postfix results of each request and checks the result stream.
`timescale 1ns / 100ps

module i2p_scoreboard import i2p_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic       req_ready_i,
  input  logic [7:0] req_ch_i,
  input  logic       req_cmd_i,
  input  logic       res_valid_i,
  input  logic       res_ready_i,
  input  logic [7:0] res_sym_i,
  input  logic [1:0] res_kind_i,
  input  logic       res_last_i,
  output int         mism_cnt_o,
  output int         pend_cnt_o
);

  typedef struct packed {
    logic [7:0] sym;
    kind_e      kind;
    logic       last;
  } post_item_t;

  post_item_t  postfix_q[$];
  logic [7:0]  op_stk [StackDepth];
  int unsigned stk_cnt;
  post_item_t  want;
  post_item_t  got;

  initial begin
    mism_cnt_o = 0;
    pend_cnt_o = 0;
  end

  // Signed precedence: an open paren and any unknown character rank lowest.
  function automatic int op_rank(input logic [7:0] c);
    if (c == CH_MUL || c == CH_DIV) begin
      return 2;
    end
    if (c == CH_ADD || c == CH_SUB) begin
      return 1;
    end
    return -1;
  endfunction

  task automatic predict_postfix(input logic cmd, input logic [7:0] ch);
    post_item_t res[$];
    logic [7:0] top_ch;
    logic       found;
    int         rank;
    if (cmd) begin
      while (stk_cnt > 0) begin
        stk_cnt--;
        res.push_back('{sym: op_stk[stk_cnt], kind: KIND_SYM, last: 1'b0});
      end
      res.push_back('{sym: 8'h00, kind: KIND_END, last: 1'b0});
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      res.push_back('{sym: ch, kind: KIND_SYM, last: 1'b0});
    end else if (ch == CH_RPAREN) begin
      found = 1'b0;
      while (stk_cnt > 0 && !found) begin
        stk_cnt--;
        top_ch = op_stk[stk_cnt];
        if (top_ch == CH_LPAREN) begin
          found = 1'b1;
        end else begin
          res.push_back('{sym: top_ch, kind: KIND_SYM, last: 1'b0});
        end
      end
      if (!found) begin
        res.push_back('{sym: 8'h00, kind: KIND_UNM, last: 1'b0});
      end
    end else begin
      // An open paren is pushed as it is; every other operator first pops
      // the entries that bind at least as tightly.
      if (ch != CH_LPAREN) begin
        rank = op_rank(ch);
        while (stk_cnt > 0 && rank <= op_rank(op_stk[stk_cnt - 1])) begin
          stk_cnt--;
          res.push_back('{sym: op_stk[stk_cnt], kind: KIND_SYM, last: 1'b0});
        end
      end
      if (stk_cnt >= StackDepth) begin
        res.push_back('{sym: 8'h00, kind: KIND_OVF, last: 1'b0});
      end else begin
        op_stk[stk_cnt] = ch;
        stk_cnt++;
      end
    end
    if (res.size() > 0) begin
      res[res.size() - 1].last = 1'b1;
    end
    foreach (res[i]) begin
      postfix_q.push_back(res[i]);
    end
  endtask

  task automatic log_mismatch(input string what, input post_item_t exp_i, input post_item_t act_i);
    mism_cnt_o++;
    if (mism_cnt_o <= 10) begin
      $display("[%0t] %s: expected sym=%02h kind=%0d last=%0b, got sym=%02h kind=%0d last=%0b",
               $time, what, exp_i.sym, exp_i.kind, exp_i.last, act_i.sym, act_i.kind, act_i.last);
    end
  endtask

  // Results are checked before the request of the same edge is predicted, so
  // a result can never be matched against its own request's expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stk_cnt = 0;
      postfix_q.delete();
      pend_cnt_o = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got = '{sym: res_sym_i, kind: kind_e'(res_kind_i), last: res_last_i};
        if (postfix_q.size() == 0) begin
          log_mismatch("unexpected result", '0, got);
        end else begin
          want = postfix_q.pop_front();
          if (want.sym != got.sym || want.kind != got.kind || want.last != got.last) begin
            log_mismatch("result mismatch", want, got);
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        predict_postfix(req_cmd_i, req_ch_i);
      end
      pend_cnt_o = postfix_q.size();
    end
  end

endmodule

FILE: tb/tb_infix_to_postfix_converter.sv
// Testbench top: clock, reset, request stimulus, result stalls, watchdog and verdict.
`timescale 1ns / 100ps

module tb_infix_to_postfix_converter;
  import i2p_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 48;
  localparam int ReqTarget   = 430;

  logic       clk_i;
  logic       rst_ni;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  int mism_cnt;
  int pend_cnt;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_reqs;
  int hold_done;
  int hold_left;
  int reqs_sent;
  int idle_cyc;

  infix_to_postfix_converter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  i2p_scoreboard i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_tvalid),
    .req_ready_i (s_tready),
    .req_ch_i    (s_tdata),
    .req_cmd_i   (s_tuser),
    .res_valid_i (m_tvalid),
    .res_ready_i (m_tready),
    .res_sym_i   (m_tdata),
    .res_kind_i  (m_tuser),
    .res_last_i  (m_tlast),
    .mism_cnt_o  (mism_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    m_tready = 1'b0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cyc <= 0;
    end else if (rst_ni) begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_op();
    case ($urandom_range(3))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input logic cmd, input logic [7:0] ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = ch;
    s_tuser  = cmd;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    reqs_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      send_req(1'b0, txt[i]);
    end
  endtask

  // Well-formed expression with random nesting, closed by an end request.
  // A deep one opens 12 to 20 parens, which may run the default 16-entry stack over.
  task automatic send_expression(input bit deep);
    int n_ops;
    int opens;
    int k;
    opens = 0;
    n_ops = $urandom_range(1, 6);
    if (deep) begin
      k = $urandom_range(12, 20);
      repeat (k) send_req(1'b0, CH_LPAREN);
      opens = k;
    end
    for (int i = 0; i <= n_ops; i++) begin
      k = $urandom_range(0, 2);
      repeat (k) send_req(1'b0, CH_LPAREN);
      opens += k;
      send_req(1'b0, rand_digit());
      k = $urandom_range(0, opens);
      repeat (k) send_req(1'b0, CH_RPAREN);
      opens -= k;
      if (i < n_ops) begin
        send_req(1'b0, rand_op());
      end
    end
    repeat (opens) send_req(1'b0, CH_RPAREN);
    send_req(1'b1, 8'($urandom));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send_req(($urandom_range(7) == 0), 8'($urandom));
    end
  endtask

  task automatic run_random(input int upto);
    int pick;
    while (reqs_sent < upto) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_expression(1'b1);
      end else if (pick < 78) begin
        send_expression(1'b0);
      end else begin
        send_noise();
      end
    end
  endtask

  // The sender stops until every expected result is back, then lets the
  // block finish any request that gives no result.
  task automatic drain();
    s_tvalid = 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    s_tuser     = 1'b0;
    tx_idle_pct = 34;
    rx_idle_pct = 75;
    hold_reqs   = 0;
    reqs_sent   = 0;
    idle_cyc    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Close paren on an empty stack, then a full expression whose trailing
    // close paren finds no open paren below an unknown operator.
    send_text(")");
    send_text("(9-0)/2*x+3)");
    send_req(1'b1, 8'h00);
    send_text("()4");
    // An unknown character at the top of the byte range pops one at the bottom.
    send_req(1'b0, 8'h00);
    send_req(1'b0, 8'hFF);
    send_req(1'b1, 8'hFF);

    run_random(150);
    drain();

    tx_idle_pct = 75;
    rx_idle_pct = 34;
    run_random(290);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs++;
    run_random(ReqTarget);
    drain();

    if (mism_cnt == 0 && pend_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/i2p_pkg.sv
design/i2p_stack.sv
design/i2p_out.sv
design/i2p_seq.sv
design/infix_to_postfix_converter.sv
design/i2p_checker.sv
tb/i2p_checker.sv
tb/tb_infix_to_postfix_converter.sv
